FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block; define ASSERT_OFF to drop
// them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// check prop at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// check that cond at one edge implies prop at the next edge
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

FILE: rtl/core/fbfl_pkg.sv
// ---------------------------------------------------------------------------
// Free list allocator package
// Request, status, register and stack operation codes shared by the block.
// ---------------------------------------------------------------------------
package fbfl_pkg;

	localparam int IDX_W = 8;
	localparam int CNT_W = 9;
	localparam int SIZE_W = 16;
	localparam int MAX_POOL = 256;
	localparam logic [SIZE_W-1:0] MIN_BLOCK_SIZE = 16'd8;
	localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 9'd256;
	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 16'd64;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_RESET = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_TOO_LARGE = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		CFG_BLOCK_COUNT = 1'b0,
		CFG_BLOCK_SIZE  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2
	} stack_op_t;

endpackage

FILE: rtl/core/fbfl_cell.sv
// ---------------------------------------------------------------------------
// Free list link cell
// One entry of the link row: holds the block that follows this block on the
// free list, loaded when the block is freed.
// ---------------------------------------------------------------------------
module fbfl_cell #(
	parameter logic [fbfl_pkg::IDX_W-1:0] INIT = '0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [fbfl_pkg::IDX_W-1:0] wr_data,
	output logic [fbfl_pkg::IDX_W-1:0] entry_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= INIT;
		end else if (wr_en) begin
			entry_q <= wr_data;
		end
	end

endmodule

FILE: rtl/core/fbfl_stack.sv
// ---------------------------------------------------------------------------
// Free list link row
// Row of cells holding the next link of every block; cell i starts linked to
// block i-1, cell 0 to block 0. One write and one registered read per cycle, write first.
// ---------------------------------------------------------------------------
module fbfl_stack #(
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [fbfl_pkg::IDX_W-1:0] wr_addr,
	input  logic [fbfl_pkg::IDX_W-1:0] wr_data,
	input  logic [fbfl_pkg::IDX_W-1:0] rd_addr,
	output logic [fbfl_pkg::IDX_W-1:0] rd_data_q
);
	import fbfl_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [IDX_W-1:0] entry [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		fbfl_cell #(
			.INIT (IDX_W'((i == 0) ? 0 : i - 1))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en && (wr_addr == IDX_W'(i))),
			.wr_data (wr_data),
			.entry_q (entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_data_q <= IDX_W'(DEPTH - 2);
		end else if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else if (int'(rd_addr) < DEPTH) begin
			rd_data_q <= entry[rd_addr[AW-1:0]];
		end else begin
			rd_data_q <= '0;
		end
	end

endmodule

FILE: rtl/core/fixed_block_free_list_allocator_top.sv
// ---------------------------------------------------------------------------
// Fixed block free list allocator
// Pool of equal-sized blocks: allocate pops a freed block or the highest
// never-used block, free links the block in as the new list head, pool reset
// rebuilds.
//
//   port group   direction  handshake              payload
//   request      in         start & !busy          req_type, block_index, request_size
//   result       out        done (one cycle)       granted, given_index, status, free_count
//   config       in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// One request per cycle; its result shows with done in the cycle after the
// start transfer, set by the output register. The link of the next list head is
// read into a register as that head is set, so pops follow each other with no gap.
// busy stays low and cfg_ready stays high.
// Reset restores the register defaults and a full pool of min(256, NUM_BLOCKS).
// The receiver cannot stall: every result is taken in its done cycle.
// ---------------------------------------------------------------------------
module fixed_block_free_list_allocator_top #(
	parameter int NUM_BLOCKS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  block_index,
	input  logic [15:0] request_size,
	output logic        done,
	output logic        granted,
	output logic [7:0]  given_index,
	output logic [1:0]  status,
	output logic [8:0]  free_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import fbfl_pkg::*;
	`include "assert_macros.svh"

	localparam int DEPTH = (NUM_BLOCKS < MAX_POOL) ? NUM_BLOCKS : MAX_POOL;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
	localparam logic [IDX_W-1:0] HEAD_RESET = IDX_W'(DEPTH - 1);

	logic [CNT_W-1:0]  block_count_q;
	logic [SIZE_W-1:0] block_size_q;
	logic [CNT_W-1:0]  pool_size_q;
	logic [CNT_W-1:0]  free_total_q;
	logic [CNT_W-1:0]  fresh_top_q;
	logic [IDX_W-1:0]  list_head_q;

	logic [CNT_W-1:0]  pool_size_d;
	logic [CNT_W-1:0]  free_total_d;
	logic [CNT_W-1:0]  fresh_top_d;
	logic [IDX_W-1:0]  list_head_d;
	logic [CNT_W-1:0]  clip_count;
	logic [SIZE_W-1:0] eff_size;
	logic [IDX_W-1:0]  head_link;
	stack_op_t         stack_op;
	logic              take;
	logic              grant_d;
	logic [IDX_W-1:0]  given_d;
	status_t           status_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RESET;
			block_size_q  <= BLOCK_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[CNT_W-1:0];
				CFG_BLOCK_SIZE:  block_size_q  <= cfg_data;
				default:         block_size_q  <= block_size_q;
			endcase
		end
	end

	assign clip_count = (block_count_q > DEPTH_CNT) ? DEPTH_CNT : block_count_q;
	assign eff_size   = (block_size_q < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : block_size_q;

	always_comb begin
		pool_size_d  = pool_size_q;
		free_total_d = free_total_q;
		fresh_top_d  = fresh_top_q;
		list_head_d  = list_head_q;
		stack_op     = OP_HOLD;
		grant_d      = 1'b0;
		given_d      = '0;
		status_d     = ST_OK;
		if (take) begin
			unique case (req_t'(req_type))
				REQ_ALLOC: begin
					priority if (request_size > eff_size) begin
						status_d = ST_TOO_LARGE;
					end else if (free_total_q == '0) begin
						status_d = ST_EXHAUSTED;
					end else if (free_total_q > fresh_top_q) begin
						stack_op     = OP_POP;
						given_d      = list_head_q;
						list_head_d  = head_link;
						grant_d      = 1'b1;
						free_total_d = free_total_q - 1'b1;
					end else begin
						fresh_top_d  = fresh_top_q - 1'b1;
						given_d      = fresh_top_d[IDX_W-1:0];
						grant_d      = 1'b1;
						free_total_d = free_total_q - 1'b1;
					end
				end
				REQ_FREE: begin
					if (({1'b0, block_index} < pool_size_q) && (free_total_q < pool_size_q)) begin
						stack_op     = OP_PUSH;
						list_head_d  = block_index;
						free_total_d = free_total_q + 1'b1;
					end
				end
				REQ_RESET: begin
					pool_size_d  = clip_count;
					free_total_d = clip_count;
					fresh_top_d  = clip_count;
					list_head_d  = clip_count[IDX_W-1:0] - 1'b1;
				end
				default: begin
					stack_op = OP_HOLD;
				end
			endcase
		end
	end

	fbfl_stack #(
		.DEPTH (DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (stack_op == OP_PUSH),
		.wr_addr   (block_index),
		.wr_data   (list_head_q),
		.rd_addr   (list_head_d),
		.rd_data_q (head_link)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q  <= DEPTH_CNT;
			free_total_q <= DEPTH_CNT;
			fresh_top_q  <= DEPTH_CNT;
			list_head_q  <= HEAD_RESET;
			done         <= 1'b0;
		end else begin
			pool_size_q  <= pool_size_d;
			free_total_q <= free_total_d;
			fresh_top_q  <= fresh_top_d;
			list_head_q  <= list_head_d;
			done         <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			granted     <= grant_d;
			given_index <= given_d;
			status      <= status_d;
			free_count  <= free_total_d;
		end
	end

	`ASSERT_ALWAYS(a_free_le_pool, clk, arst_n, free_total_q <= pool_size_q,
		"free count exceeds pool size")
	`ASSERT_ALWAYS(a_fresh_le_free, clk, arst_n, fresh_top_q <= free_total_q,
		"fresh blocks exceed free count")
	`ASSERT_ALWAYS(a_pool_le_depth, clk, arst_n, pool_size_q <= DEPTH_CNT,
		"pool size exceeds stack depth")
	`ASSERT_NEXT(a_done_follows, clk, arst_n, take, done && free_count == free_total_q,
		"result missing or free count mismatch after transfer")
	`ASSERT_NEXT(a_no_extra_done, clk, arst_n, !take, !done,
		"result without a request transfer")

endmodule

FILE: tb/sv/tb_fixed_block_free_list_allocator_top.sv
// ---------------------------------------------------------------------------
// Free list allocator testbench
// Drives allocate, free, pool reset and no-op requests through the command
// port. A cycle-level model of the LIFO free list predicts every result, and
// each done strobe is checked field by field. The run steps through several
// pool counts and block sizes, including the clipped and empty extremes.
// ---------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fbfl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		req_t        kind;
		logic [7:0]  blk;
		logic [15:0] bytes;
	} alloc_req_t;

	typedef struct {
		logic       granted;
		logic [7:0] blk;
		status_t    status;
		logic [8:0] free_count;
	} outcome_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = REQ_NOP;
	logic [7:0]  block_index = '0;
	logic [15:0] request_size = '0;
	logic        done;
	logic        granted;
	logic [7:0]  given_index;
	logic [1:0]  status;
	logic [8:0]  free_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = CFG_BLOCK_COUNT;
	logic [15:0] cfg_data = '0;

	alloc_req_t queued_requests[$];
	outcome_t   pending_outcomes[$];
	alloc_req_t taken;
	alloc_req_t upcoming;
	outcome_t   seen;

	logic [7:0]  next_link[MAX_POOL];
	logic [7:0]  list_head;
	logic [8:0]  free_total;
	logic [8:0]  fresh_top;
	logic [8:0]  pool_size;
	logic [8:0]  blk_count;
	logic [15:0] blk_size;

	int idle_pct = 0;
	int errors = 0;
	int cycle_count = 0;
	int n_requests = 0;
	int n_grants = 0;
	int n_exhausted = 0;
	int n_refused = 0;
	int n_settings = 1;

	fixed_block_free_list_allocator_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.block_index  (block_index),
		.request_size (request_size),
		.done         (done),
		.granted      (granted),
		.given_index  (given_index),
		.status       (status),
		.free_count   (free_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic void relatch_pool();
		logic [8:0] n;
		n = blk_count;
		if (n > MAX_POOL)
			n = 9'(MAX_POOL);
		pool_size = n;
		free_total = n;
		fresh_top = n;
		list_head = n[7:0] - 8'd1;
	endfunction

	function automatic void reset_pool_state();
		blk_count = BLOCK_COUNT_RESET;
		blk_size = BLOCK_SIZE_RESET;
		for (int i = 0; i < MAX_POOL; i++)
			next_link[i] = (i == 0) ? 8'd0 : 8'(i - 1);
		relatch_pool();
	endfunction

	function automatic outcome_t apply_pool_request(alloc_req_t r);
		outcome_t o;
		logic [15:0] eff;
		o.granted = 1'b0;
		o.blk = '0;
		o.status = ST_OK;
		eff = (blk_size < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : blk_size;
		case (r.kind)
			REQ_ALLOC: begin
				if (r.bytes > eff) begin
					o.status = ST_TOO_LARGE;
				end else if (free_total == 0) begin
					o.status = ST_EXHAUSTED;
				end else if (free_total > fresh_top) begin
					o.blk = list_head;
					list_head = next_link[list_head];
					free_total--;
					o.granted = 1'b1;
				end else begin
					fresh_top--;
					o.blk = fresh_top[7:0];
					free_total--;
					o.granted = 1'b1;
				end
			end
			REQ_FREE: begin
				if ({1'b0, r.blk} < pool_size && free_total < pool_size) begin
					next_link[r.blk] = list_head;
					list_head = r.blk;
					free_total++;
				end
			end
			REQ_RESET: relatch_pool();
			default: ;
		endcase
		o.free_count = free_total;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= REQ_NOP;
			block_index <= '0;
			request_size <= '0;
		end else begin
			if (start && !busy) begin
				taken.kind = req_t'(req_type);
				taken.blk = block_index;
				taken.bytes = request_size;
				pending_outcomes.push_back(apply_pool_request(taken));
				n_requests++;
			end
			if (!start || !busy) begin
				if (queued_requests.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
					upcoming = queued_requests.pop_front();
					start <= 1'b1;
					req_type <= upcoming.kind;
					block_index <= upcoming.blk;
					request_size <= upcoming.bytes;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result with no request outstanding, actual free_count %0d",
					$time, free_count);
				errors++;
			end else begin
				seen = pending_outcomes.pop_front();
				check_field("granted", seen.granted, granted);
				check_field("given_index", seen.blk, given_index);
				check_field("status", seen.status, status);
				check_field("free_count", seen.free_count, free_count);
				if (seen.granted)
					n_grants++;
				if (seen.status == ST_EXHAUSTED)
					n_exhausted++;
				if (seen.status == ST_TOO_LARGE)
					n_refused++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d results outstanding",
				$time, pending_outcomes.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic void queue_request(req_t kind, logic [7:0] blk, logic [15:0] bytes);
		alloc_req_t r;
		r.kind = kind;
		r.blk = blk;
		r.bytes = bytes;
		queued_requests.push_back(r);
	endfunction

	task automatic drain();
		while (queued_requests.size() != 0 || start || pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_BLOCK_COUNT)
			blk_count = value[8:0];
		else
			blk_size = value;
	endtask

	task automatic queue_traffic(int items, int ps, int eff);
		int left, burst, mode, pick, sz, ix;
		left = items;
		while (left > 0) begin
			mode = $urandom_range(99, 0);
			burst = $urandom_range(ps + 2, 1);
			if (mode >= 85 && burst > 4)
				burst = 4;
			if (burst > left)
				burst = left;
			for (int k = 0; k < burst; k++) begin
				pick = $urandom_range(99, 0);
				if (mode < 45) begin
					if (pick < 85)
						sz = $urandom_range(eff, 0);
					else if (pick < 95 && eff < 65535)
						sz = $urandom_range(65535, eff + 1);
					else
						sz = $urandom_range(65535, 0);
					queue_request(REQ_ALLOC, 8'($urandom), 16'(sz));
				end else if (mode < 85) begin
					if (ps > 0 && pick < 85)
						ix = $urandom_range(ps - 1, 0);
					else
						ix = $urandom_range(255, 0);
					queue_request(REQ_FREE, 8'(ix), 16'($urandom));
				end else begin
					queue_request(req_t'($urandom_range(3, 0)), 8'($urandom), 16'($urandom));
				end
			end
			left -= burst;
		end
	endtask

	task automatic run_setting(logic [15:0] count_val, logic [15:0] size_val, int pct,
			int items);
		int ps, eff;
		write_reg(CFG_BLOCK_COUNT, count_val);
		write_reg(CFG_BLOCK_SIZE, size_val);
		ps = (count_val[8:0] > MAX_POOL) ? MAX_POOL : count_val[8:0];
		eff = (size_val < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : size_val;
		idle_pct = pct;
		queue_request(REQ_RESET, 8'($urandom), 16'($urandom));
		queue_traffic(items, ps, eff);
		drain();
		n_settings++;
	endtask

	initial begin
		reset_pool_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// default pool: fresh pops, size refusal, freed-list reuse, unchecked free
		queue_request(REQ_ALLOC, 8'd0, 16'd0);
		queue_request(REQ_ALLOC, 8'hFF, 16'd64);
		queue_request(REQ_ALLOC, 8'd0, 16'd65);
		queue_request(REQ_ALLOC, 8'd0, 16'hFFFF);
		queue_request(REQ_FREE, 8'd255, 16'hFFFF);
		queue_request(REQ_ALLOC, 8'd0, 16'd64);
		queue_request(REQ_FREE, 8'd0, 16'd0);
		queue_request(REQ_ALLOC, 8'd0, 16'd1);
		queue_request(REQ_ALLOC, 8'd0, 16'd1);
		queue_request(REQ_NOP, 8'hFF, 16'hFFFF);
		queue_request(REQ_RESET, 8'd0, 16'd0);
		queue_request(REQ_FREE, 8'd17, 16'd0);
		queue_request(REQ_ALLOC, 8'd0, 16'd8);
		drain();

		// tiny pool, block size raised to the minimum, exhaustion, out-of-pool free
		write_reg(CFG_BLOCK_COUNT, 16'd3);
		write_reg(CFG_BLOCK_SIZE, 16'd0);
		queue_request(REQ_RESET, 8'd0, 16'd0);
		queue_request(REQ_ALLOC, 8'd0, 16'd9);
		queue_request(REQ_ALLOC, 8'd0, 16'd8);
		queue_request(REQ_ALLOC, 8'd0, 16'd0);
		queue_request(REQ_ALLOC, 8'd0, 16'd0);
		queue_request(REQ_ALLOC, 8'd0, 16'd0);
		queue_request(REQ_FREE, 8'd200, 16'd0);
		queue_request(REQ_FREE, 8'd1, 16'd0);
		queue_request(REQ_ALLOC, 8'd0, 16'd0);
		drain();

		// empty pool
		write_reg(CFG_BLOCK_COUNT, 16'd0);
		queue_request(REQ_RESET, 8'd0, 16'd0);
		queue_request(REQ_ALLOC, 8'd0, 16'd0);
		queue_request(REQ_FREE, 8'd0, 16'd0);
		drain();
		n_settings += 2;

		run_setting(16'd8, 16'd64, 0, 150);
		run_setting(16'd256, 16'hFFFF, 50, 200);
		run_setting(16'($urandom_range(64, 2)), 16'($urandom_range(65535, 8)), 26, 150);
		run_setting(16'd1, 16'd7, 50, 60);
		run_setting(16'd511, 16'd0, 0, 100);
		run_setting(16'($urandom_range(256, 1)), 16'($urandom_range(65535, 8)), 26, 100);

		repeat (8) @(posedge clk);
		$display("covered %0d requests across %0d pool settings", n_requests, n_settings);
		$display("%0d grants, %0d exhausted, %0d oversize refusals, %0d errors",
			n_grants, n_exhausted, n_refused, errors);
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
